>>> src/adc_short_circuit_detector_core_assert.svh
// Assertion macros for the ADC short-circuit detector.
// Needs nothing else; include it inside a module body.
`ifndef ADC_SHORT_CIRCUIT_DETECTOR_CORE_ASSERT_SVH
`define ADC_SHORT_CIRCUIT_DETECTOR_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define ASCD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// A condition in one cycle that requires another in the next cycle.
`define ASCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ascd_pkg.sv
// Shared types and constants for the ADC short-circuit detector.
// No dependencies.
package ascd_pkg;

	// Frame geometry and converter resolution.
	localparam int SAMPLES_PER_FRAME = 160;
	localparam int SAMPLE_BITS       = 12;

	// Field widths.
	localparam int CHAN_W   = 4;
	localparam int CODE_W   = 12;
	localparam int LIMIT_W  = 8;
	localparam int HOLD_W   = 16;
	localparam int POS_W    = 8;
	localparam int TALLY_W  = 8;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Mask applied to the raw code for the configured converter resolution.
	localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLES_PER_FRAME - 1);

	// Sample kind codes.
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VOLTAGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CURRENT = 2'd2;

	// Operation codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_CHAN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_CHAN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES  = 3'd4;

	// Configuration reset values.
	localparam logic [CHAN_W-1:0]  RST_VOLTAGE_CHAN = 4'd0;
	localparam logic [CHAN_W-1:0]  RST_CURRENT_CHAN = 4'd1;
	localparam logic [CODE_W-1:0]  RST_FULL_SCALE   = 12'd4095;
	localparam logic [LIMIT_W-1:0] RST_SAT_LIMIT    = 8'd72;
	localparam logic [HOLD_W-1:0]  RST_HOLD_FRAMES  = 16'd5;

	typedef struct packed {
		logic              operation;
		logic [CHAN_W-1:0] chan_tag;
		logic [CODE_W-1:0] sample_code;
		logic              track_enabled;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] sample_kind;
		logic [CODE_W-1:0] sample_value;
		logic              frame_end;
		logic              fault_latched;
		logic              fault_event;
	} out_item_t;

endpackage

>>> src/adc_short_circuit_detector_core.sv
// Top level of the ADC short-circuit detector: sorting, frame tally and fault latch.
// Depends on ascd_pkg and adc_short_circuit_detector_core_assert.svh.
// Each result is registered into the output buffer on its input transfer.
// Throughput: one item per cycle while in_ready is high; a two-entry output buffer keeps input open while
// one result waits, so in_ready falls only when both entries are full.
// Reset clears frame position, tally, fault flag and buffer; configuration returns
// to its defaults and the persistence counter loads the default hold count.
module adc_short_circuit_detector_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  ascd_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output ascd_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [ascd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ascd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// Configuration registers.
	logic [ascd_pkg::CHAN_W-1:0]  voltage_chan_q;
	logic [ascd_pkg::CHAN_W-1:0]  current_chan_q;
	logic [ascd_pkg::CODE_W-1:0]  full_scale_q;
	logic [ascd_pkg::LIMIT_W-1:0] sat_limit_q;
	logic [ascd_pkg::HOLD_W-1:0]  hold_frames_q;

	// Detector state.
	logic [ascd_pkg::POS_W-1:0]   frame_pos_q;
	logic [ascd_pkg::TALLY_W-1:0] tally_q;
	logic [ascd_pkg::HOLD_W-1:0]  frames_left_q;
	logic                         fault_q;

	// Output buffer.
	ascd_pkg::out_item_t out_q;
	ascd_pkg::out_item_t skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;

	// Next-state and result logic.
	logic [ascd_pkg::CODE_W-1:0]  code;
	logic [ascd_pkg::TALLY_W-1:0] tally_new;
	logic [ascd_pkg::POS_W-1:0]   frame_pos_d;
	logic [ascd_pkg::TALLY_W-1:0] tally_d;
	logic [ascd_pkg::HOLD_W-1:0]  frames_left_d;
	logic                         fault_d;
	logic                         is_last;
	logic                         qualifies;
	ascd_pkg::out_item_t          result;
	logic                         push;
	logic                         pop;

	assign code      = in_data.sample_code & ascd_pkg::CODE_MASK;
	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_chan_q <= ascd_pkg::RST_VOLTAGE_CHAN;
			current_chan_q <= ascd_pkg::RST_CURRENT_CHAN;
			full_scale_q   <= ascd_pkg::RST_FULL_SCALE;
			sat_limit_q    <= ascd_pkg::RST_SAT_LIMIT;
			hold_frames_q  <= ascd_pkg::RST_HOLD_FRAMES;
		end else if (cfg_we) begin
			case (cfg_index)
				ascd_pkg::REG_VOLTAGE_CHAN: voltage_chan_q <= cfg_wdata[ascd_pkg::CHAN_W-1:0];
				ascd_pkg::REG_CURRENT_CHAN: current_chan_q <= cfg_wdata[ascd_pkg::CHAN_W-1:0];
				ascd_pkg::REG_FULL_SCALE:   full_scale_q   <= cfg_wdata[ascd_pkg::CODE_W-1:0];
				ascd_pkg::REG_SAT_LIMIT:    sat_limit_q    <= cfg_wdata[ascd_pkg::LIMIT_W-1:0];
				ascd_pkg::REG_HOLD_FRAMES:  hold_frames_q  <= cfg_wdata[ascd_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// Clear the fault, or sort a sample, update the tally and run the persistence counter.
	always_comb begin
		result        = '0;
		tally_new     = tally_q;
		frame_pos_d   = frame_pos_q;
		tally_d       = tally_q;
		frames_left_d = frames_left_q;
		fault_d       = fault_q;
		is_last       = 1'b0;
		qualifies     = 1'b0;
		if (in_data.operation == ascd_pkg::OP_CLEAR) begin
			fault_d       = 1'b0;
			frames_left_d = hold_frames_q;
		end else begin
			// Voltage wins when both channel numbers are the same.
			if (in_data.chan_tag == voltage_chan_q) begin
				result.sample_kind  = ascd_pkg::KIND_VOLTAGE;
				result.sample_value = code;
			end else if (in_data.chan_tag == current_chan_q) begin
				result.sample_kind  = ascd_pkg::KIND_CURRENT;
				result.sample_value = code;
				if (code == full_scale_q && tally_q != '1) begin
					tally_new = tally_q + ascd_pkg::TALLY_W'(1);
				end
			end
			is_last   = frame_pos_q >= ascd_pkg::LAST_POS;
			qualifies = !fault_q && (tally_new > sat_limit_q) && in_data.track_enabled;
			if (is_last) begin
				result.frame_end = 1'b1;
				if (qualifies) begin
					if (frames_left_q <= ascd_pkg::HOLD_W'(1)) begin
						fault_d            = 1'b1;
						result.fault_event = 1'b1;
						frames_left_d      = hold_frames_q;
					end else begin
						frames_left_d = frames_left_q - ascd_pkg::HOLD_W'(1);
					end
				end else begin
					frames_left_d = hold_frames_q;
				end
				frame_pos_d = '0;
				tally_d     = '0;
			end else begin
				frame_pos_d = frame_pos_q + ascd_pkg::POS_W'(1);
				tally_d     = tally_new;
			end
		end
		result.fault_latched = fault_d;
	end

	// Detector state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q   <= '0;
			tally_q       <= '0;
			frames_left_q <= ascd_pkg::RST_HOLD_FRAMES;
			fault_q       <= 1'b0;
		end else if (push) begin
			frame_pos_q   <= frame_pos_d;
			tally_q       <= tally_d;
			frames_left_q <= frames_left_d;
			fault_q       <= fault_d;
		end
	end

	// Two-entry output buffer: the skid entry catches a result while the head waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers of the output buffer.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	// Checks on buffer ordering, fault reporting, clear release and frame counting.
	`include "adc_short_circuit_detector_core_assert.svh"

	`ASCD_ASSERT(a_skid_needs_head, clk, arst_n, !skid_valid_q || out_valid_q, "skid entry filled while head empty")
	`ASCD_ASSERT(a_event_implies_latch, clk, arst_n, !(out_valid_q && out_q.fault_event) || (out_q.fault_latched && out_q.frame_end), "fault event without latch or frame end")
	`ASCD_ASSERT(a_frame_pos_range, clk, arst_n, frame_pos_q <= ascd_pkg::LAST_POS, "frame position beyond frame length")
	`ASCD_ASSERT_NEXT(a_clear_releases, clk, arst_n, push && in_data.operation == ascd_pkg::OP_CLEAR, !fault_q, "clear transfer did not release the fault")

endmodule
